FILE: rtl/core/pnam_pkg.sv
// shared types and constants for the packed nibble audio mixer
`timescale 1ns / 1ps
`default_nettype none

package pnam_pkg;

    localparam int SAMPLE_W         = 4;
    localparam int WORD_W           = 32;
    localparam int BASE_W           = 12;
    localparam int LEN_W            = 13;
    localparam int NIB_IDX_W        = 4;
    localparam int ADDR_SUM_W       = 14;
    localparam int COUNT_OUT_W      = 3;
    localparam int TOP_NIB_LSB      = 28;
    localparam int NEXT_NIB_LSB     = 24;
    localparam logic [NIB_IDX_W-1:0] NIBBLES_PER_WORD = 4'd8;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_PLAY = 2'd1,
        CMD_STOP = 2'd2,
        CMD_LOAD = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BASE_W-1:0] sound_base;
        logic [LEN_W-1:0]  sound_len;
        logic [BASE_W-1:0] load_addr;
        logic [WORD_W-1:0] load_data;
    } req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]    sample;
        logic                   sample_valid;
        logic                   timer_running;
        logic                   play_accepted;
        logic [COUNT_OUT_W-1:0] active_count;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FETCH,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic item_load;
        logic tick_start;
        logic scan;
        logic fetch;
        logic div_start;
        logic div_step;
        logic play;
        logic stop;
        logic store_write;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t item_cmd;
        logic need_fetch;
        logic last_chan;
        logic count_zero;
        logic div_last;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/pnam_ctrl.sv
// controller state machine that sequences each request through the datapath
`timescale 1ns / 1ps
`default_nettype none

module pnam_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_ready,
    input  wire pnam_pkg::ctrl_status_t  status,
    output pnam_pkg::ctrl_cmd_t          cmd
);

    pnam_pkg::state_t state_reg;
    pnam_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pnam_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            pnam_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = pnam_pkg::ST_DECODE;
                end
            end
            pnam_pkg::ST_DECODE:
            begin
                unique case (status.item_cmd)
                    pnam_pkg::CMD_TICK:
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = pnam_pkg::ST_SCAN;
                    end
                    pnam_pkg::CMD_PLAY:
                    begin
                        cmd.play   = 1'b1;
                        state_next = pnam_pkg::ST_DONE;
                    end
                    pnam_pkg::CMD_STOP:
                    begin
                        cmd.stop   = 1'b1;
                        state_next = pnam_pkg::ST_DONE;
                    end
                    pnam_pkg::CMD_LOAD:
                    begin
                        cmd.store_write = 1'b1;
                        state_next      = pnam_pkg::ST_DONE;
                    end
                    default:
                    begin
                        state_next = pnam_pkg::ST_DONE;
                    end
                endcase
            end
            pnam_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (status.need_fetch)
                begin
                    state_next = pnam_pkg::ST_FETCH;
                end
                else if (status.last_chan)
                begin
                    state_next = pnam_pkg::ST_DIV_INIT;
                end
                else
                begin
                    state_next = pnam_pkg::ST_SCAN;
                end
            end
            pnam_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (status.last_chan)
                begin
                    state_next = pnam_pkg::ST_DIV_INIT;
                end
                else
                begin
                    state_next = pnam_pkg::ST_SCAN;
                end
            end
            pnam_pkg::ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                if (status.count_zero)
                begin
                    state_next = pnam_pkg::ST_DONE;
                end
                else
                begin
                    state_next = pnam_pkg::ST_DIV;
                end
            end
            pnam_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = pnam_pkg::ST_DONE;
                end
            end
            pnam_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pnam_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pnam_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/pnam_datapath.sv
// datapath: channel registers, sample store, mix accumulator, divider and output register
`timescale 1ns / 1ps
`default_nettype none

module pnam_datapath #(
    parameter int CHANNELS    = 4,
    parameter int STORE_WORDS = 4096
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pnam_pkg::req_t          req,
    input  wire pnam_pkg::ctrl_cmd_t     cmd,
    output pnam_pkg::ctrl_status_t       status,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output pnam_pkg::res_t               res
);

    localparam int IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW  = $clog2(STORE_WORDS);
    localparam int CW  = $clog2(CHANNELS + 1);
    localparam int SW  = $clog2(CHANNELS * 15 + 1);
    localparam int DCW = $clog2(SW);

    localparam int WW = pnam_pkg::WORD_W;
    localparam int BW = pnam_pkg::BASE_W;
    localparam int LW = pnam_pkg::LEN_W;
    localparam int NW = pnam_pkg::NIB_IDX_W;
    localparam int XW = pnam_pkg::SAMPLE_W;

    // channel state
    logic          active_reg [CHANNELS];
    logic [BW-1:0] base_reg   [CHANNELS];
    logic [LW-1:0] len_reg    [CHANNELS];
    logic [LW-1:0] word_reg   [CHANNELS];
    logic [NW-1:0] nib_reg    [CHANNELS];
    logic [WW-1:0] shift_reg  [CHANNELS];

    logic [WW-1:0] store [STORE_WORDS];
    logic [WW-1:0] rd_data_reg;

    pnam_pkg::req_t item_reg;
    logic [IW-1:0]  chan_idx_reg;
    logic [SW-1:0]  sum_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  rem_reg;
    logic [SW-1:0]  quo_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic           tick_running_reg;
    logic           play_ok_reg;
    logic           out_valid_reg;
    pnam_pkg::res_t out_data_reg;

    logic                               cur_active;
    logic [BW-1:0]                      cur_base;
    logic [LW-1:0]                      cur_len;
    logic [LW-1:0]                      cur_word;
    logic [NW-1:0]                      cur_nib;
    logic [WW-1:0]                      cur_shift;
    logic                               word_done;
    logic [LW-1:0]                      word_inc;
    logic                               chan_ends;
    logic                               need_fetch;
    logic [pnam_pkg::ADDR_SUM_W-1:0]    fetch_sum;
    logic [AW-1:0]                      fetch_addr;
    logic                               free_found;
    logic [IW-1:0]                      free_idx;
    logic [CW:0]                        trial;
    logic                               trial_ge;
    logic [CW-1:0]                      rem_next;
    logic                               is_tick;
    logic                               is_play;
    logic                               tick_valid;
    pnam_pkg::res_t                     out_next;

    assign cur_active = active_reg[chan_idx_reg];
    assign cur_base   = base_reg[chan_idx_reg];
    assign cur_len    = len_reg[chan_idx_reg];
    assign cur_word   = word_reg[chan_idx_reg];
    assign cur_nib    = nib_reg[chan_idx_reg];
    assign cur_shift  = shift_reg[chan_idx_reg];

    assign word_done  = (cur_nib == pnam_pkg::NIBBLES_PER_WORD);
    assign word_inc   = cur_word + LW'(1);
    assign chan_ends  = word_done && (word_inc >= cur_len);
    assign need_fetch = cur_active && !chan_ends && (word_done || (cur_nib == '0));
    // next word address folds the word advance in as a carry
    assign fetch_sum  = pnam_pkg::ADDR_SUM_W'(cur_base) + pnam_pkg::ADDR_SUM_W'(cur_word)
                      + pnam_pkg::ADDR_SUM_W'(word_done);
    assign fetch_addr = AW'(fetch_sum);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (!free_found && !active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // restoring divider, one quotient bit per step
    assign trial    = {rem_reg, quo_reg[SW-1]};
    assign trial_ge = (trial >= {1'b0, count_reg});
    assign rem_next = trial_ge ? CW'(trial - {1'b0, count_reg}) : CW'(trial);

    always_ff @(posedge clk)
    begin
        if (cmd.store_write)
        begin
            store[AW'(item_reg.load_addr)] <= item_reg.load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store[fetch_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                active_reg[i] <= 1'b0;
                base_reg[i]   <= '0;
                len_reg[i]    <= '0;
                word_reg[i]   <= '0;
                nib_reg[i]    <= '0;
                shift_reg[i]  <= '0;
            end
        end
        else
        begin
            priority if (cmd.stop)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    active_reg[i] <= 1'b0;
                    base_reg[i]   <= '0;
                    len_reg[i]    <= '0;
                    word_reg[i]   <= '0;
                    nib_reg[i]    <= '0;
                    shift_reg[i]  <= '0;
                end
            end
            else if (cmd.play)
            begin
                if (free_found)
                begin
                    active_reg[free_idx] <= 1'b1;
                    base_reg[free_idx]   <= item_reg.sound_base;
                    len_reg[free_idx]    <= item_reg.sound_len;
                    word_reg[free_idx]   <= '0;
                    nib_reg[free_idx]    <= '0;
                    shift_reg[free_idx]  <= '0;
                end
            end
            else if (cmd.scan)
            begin
                if (cur_active)
                begin
                    priority if (chan_ends)
                    begin
                        active_reg[chan_idx_reg] <= 1'b0;
                        base_reg[chan_idx_reg]   <= '0;
                        len_reg[chan_idx_reg]    <= '0;
                        word_reg[chan_idx_reg]   <= '0;
                        nib_reg[chan_idx_reg]    <= '0;
                        shift_reg[chan_idx_reg]  <= '0;
                    end
                    else if (need_fetch)
                    begin
                        if (word_done)
                        begin
                            word_reg[chan_idx_reg] <= word_inc;
                        end
                        nib_reg[chan_idx_reg] <= '0;
                    end
                    else
                    begin
                        shift_reg[chan_idx_reg] <= {cur_shift[WW-5:0], 4'h0};
                        nib_reg[chan_idx_reg]   <= cur_nib + NW'(1);
                    end
                end
            end
            else if (cmd.fetch)
            begin
                shift_reg[chan_idx_reg] <= rd_data_reg;
                nib_reg[chan_idx_reg]   <= NW'(1);
            end
            else
            begin
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_idx_reg <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
        end
        else
        begin
            priority if (cmd.tick_start)
            begin
                chan_idx_reg <= '0;
                sum_reg      <= '0;
                count_reg    <= '0;
            end
            else if (cmd.scan)
            begin
                if (!need_fetch)
                begin
                    chan_idx_reg <= chan_idx_reg + IW'(1);
                end
                if (cur_active && !chan_ends && !need_fetch)
                begin
                    sum_reg   <= sum_reg + SW'(cur_shift[pnam_pkg::NEXT_NIB_LSB +: XW]);
                    count_reg <= count_reg + CW'(1);
                end
            end
            else if (cmd.fetch)
            begin
                chan_idx_reg <= chan_idx_reg + IW'(1);
                sum_reg      <= sum_reg + SW'(rd_data_reg[pnam_pkg::TOP_NIB_LSB +: XW]);
                count_reg    <= count_reg + CW'(1);
            end
            else
            begin
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            quo_reg     <= sum_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            quo_reg     <= {quo_reg[SW-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_running_reg <= 1'b0;
            play_ok_reg      <= 1'b0;
        end
        else
        begin
            priority if (cmd.play)
            begin
                play_ok_reg <= free_found;
                if (free_found)
                begin
                    tick_running_reg <= 1'b1;
                end
            end
            else if (cmd.stop)
            begin
                tick_running_reg <= 1'b0;
            end
            else if (cmd.div_start && (count_reg == '0))
            begin
                tick_running_reg <= 1'b0;
            end
            else
            begin
            end
        end
    end

    assign is_tick    = (item_reg.cmd == pnam_pkg::CMD_TICK);
    assign is_play    = (item_reg.cmd == pnam_pkg::CMD_PLAY);
    assign tick_valid = is_tick && (count_reg != '0);

    always_comb
    begin
        out_next.sample        = tick_valid ? quo_reg[XW-1:0] : '0;
        out_next.sample_valid  = tick_valid;
        out_next.timer_running = tick_running_reg;
        out_next.play_accepted = is_play && play_ok_reg;
        out_next.active_count  = is_tick ? pnam_pkg::COUNT_OUT_W'(count_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    assign status.item_cmd   = pnam_pkg::cmd_t'(item_reg.cmd);
    assign status.need_fetch = need_fetch;
    assign status.last_chan  = (chan_idx_reg == IW'(CHANNELS - 1));
    assign status.count_zero = (count_reg == '0);
    assign status.div_last   = (div_cnt_reg == DCW'(SW - 1));
    assign status.out_free   = !out_valid_reg || res_ready;

endmodule

`default_nettype wire

FILE: rtl/core/packed_nibble_audio_mixer.sv
// top level of the packed nibble audio mixer
`timescale 1ns / 1ps
`default_nettype none

// Mixes up to CHANNELS voices of 4-bit audio packed eight nibbles to a 32-bit word, most
// significant nibble first, from a STORE_WORDS word sample store (STORE_WORDS a power of two;
// addresses wrap). One request is handled at a time and every request returns one result.
// Load, play and stop-all act in the decode state and load the result register in the done state.
// A tick walks the channels one per cycle through a single store read port, with an extra fetch
// state on each channel that starts a new word, then divides the nibble sum by the active count
// with a restoring divider of one bit per cycle; a tick with no active channel skips the divider
// steps. The result register lets the next request enter while a result waits to be taken. The
// store has no reset.
module packed_nibble_audio_mixer #(
    parameter int CHANNELS    = 4,
    parameter int STORE_WORDS = 4096
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire pnam_pkg::req_t  req,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output pnam_pkg::res_t       res
);

    pnam_pkg::ctrl_cmd_t    ctrl_cmd;
    pnam_pkg::ctrl_status_t ctrl_status;

    pnam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (ctrl_status),
        .cmd       (ctrl_cmd)
    );

    pnam_datapath #(
        .CHANNELS    (CHANNELS),
        .STORE_WORDS (STORE_WORDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (ctrl_cmd),
        .status    (ctrl_status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in flight");

    // a mixed sample implies the tick source is still enabled
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.sample_valid) |-> res.timer_running)
        else $error("sample produced with tick source disabled");

    // result register never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.out_load |-> ctrl_status.out_free)
        else $error("result register overwritten");

    // a store fetch only follows a scan that asked for one
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.fetch |-> $past(ctrl_cmd.scan && ctrl_status.need_fetch))
        else $error("fetch without a pending store read");

endmodule

`default_nettype wire

FILE: sim/tb_packed_nibble_audio_mixer.sv
// self-checking testbench for the packed nibble audio mixer, directed and random requests
`timescale 1ns / 1ps

module tb_packed_nibble_audio_mixer;
    import pnam_pkg::*;

    localparam int NCHAN        = 4;
    localparam int STORE_DEPTH  = 4096;
    localparam int RAND_ITEMS   = 1030;
    localparam int STEADY_LO    = 400;
    localparam int STEADY_HI    = 650;
    localparam int DRAIN_CYCLES = 40;

    class mix_tracker;
        bit        busy[NCHAN];
        bit [11:0] base[NCHAN];
        bit [12:0] length[NCHAN];
        bit [12:0] word_idx[NCHAN];
        bit [3:0]  nib_idx[NCHAN];
        bit [31:0] shifter[NCHAN];
        bit        running;
        bit [31:0] store[STORE_DEPTH];
        bit        written[STORE_DEPTH];
        res_t      expected_mix[$];
        int        errors;
        int        n_req, n_tick, n_mixed, n_play, n_refused, n_stop, n_load, max_voices;

        function void clear_voice(int c);
            busy[c]     = 1'b0;
            base[c]     = '0;
            length[c]   = '0;
            word_idx[c] = '0;
            nib_idx[c]  = '0;
            shifter[c]  = '0;
        endfunction

        // true when the next tick would fetch a word that was never loaded
        function bit tick_needs_word(output bit [11:0] addr);
            bit [12:0] wi;
            addr = '0;
            for (int c = 0; c < NCHAN; c++)
            begin
                if (!busy[c])
                    continue;
                wi = word_idx[c];
                if (nib_idx[c] == NIBBLES_PER_WORD)
                begin
                    wi = wi + 13'd1;
                    if (wi >= length[c])
                        continue;
                end
                else if (nib_idx[c] != 4'd0)
                    continue;
                addr = base[c] + wi[11:0];
                if (!written[addr])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void apply_request(req_t r);
            res_t      e;
            int        sum;
            int        cnt;
            bit [11:0] a;
            e   = '0;
            sum = 0;
            cnt = 0;
            n_req++;
            case (r.cmd)
                CMD_TICK:
                begin
                    n_tick++;
                    for (int c = 0; c < NCHAN; c++)
                    begin
                        if (!busy[c])
                            continue;
                        if (nib_idx[c] == NIBBLES_PER_WORD)
                        begin
                            word_idx[c] = word_idx[c] + 13'd1;
                            if (word_idx[c] >= length[c])
                            begin
                                clear_voice(c);
                                continue;
                            end
                            nib_idx[c] = '0;
                        end
                        if (nib_idx[c] == 4'd0)
                        begin
                            a = base[c] + word_idx[c][11:0];
                            shifter[c] = store[a];
                        end
                        else
                            shifter[c] = shifter[c] << 4;
                        nib_idx[c] = nib_idx[c] + 4'd1;
                        sum += shifter[c][31:28];
                        cnt++;
                    end
                    if (cnt == 0)
                        running = 1'b0;
                    else
                    begin
                        e.sample       = SAMPLE_W'(sum / cnt);
                        e.sample_valid = 1'b1;
                        n_mixed++;
                    end
                    e.active_count = COUNT_OUT_W'(cnt);
                    if (cnt > max_voices)
                        max_voices = cnt;
                end
                CMD_PLAY:
                begin
                    n_play++;
                    for (int c = 0; c < NCHAN; c++)
                    begin
                        if (!busy[c])
                        begin
                            busy[c]         = 1'b1;
                            base[c]         = r.sound_base;
                            length[c]       = r.sound_len;
                            running         = 1'b1;
                            e.play_accepted = 1'b1;
                            break;
                        end
                    end
                    if (!e.play_accepted)
                        n_refused++;
                end
                CMD_STOP:
                begin
                    n_stop++;
                    for (int c = 0; c < NCHAN; c++)
                        clear_voice(c);
                    running = 1'b0;
                end
                default:
                begin
                    n_load++;
                    store[r.load_addr]   = r.load_data;
                    written[r.load_addr] = 1'b1;
                end
            endcase
            e.timer_running = running;
            expected_mix.push_back(e);
        endfunction

        function void check_result(res_t got);
            res_t e;
            if (expected_mix.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h with nothing pending", got);
                return;
            end
            e = expected_mix.pop_front();
            if (got.sample !== e.sample || got.sample_valid !== e.sample_valid ||
                got.timer_running !== e.timer_running ||
                got.play_accepted !== e.play_accepted || got.active_count !== e.active_count)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: exp sample %0d valid %0b timer %0b play %0b voices %0d",
                             e.sample, e.sample_valid, e.timer_running, e.play_accepted,
                             e.active_count);
                    $display("          got sample %h valid %b timer %b play %b voices %h",
                             got.sample, got.sample_valid, got.timer_running,
                             got.play_accepted, got.active_count);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;
    bit   steady = 1'b0;

    mix_tracker tracker = new();

    packed_nibble_audio_mixer #(
        .CHANNELS    (NCHAN),
        .STORE_WORDS (STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            tracker.check_result(res);
        res_ready <= steady || ($urandom_range(0, 99) >= 30);
    end

    task automatic push_request(input req_t r);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 30)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        tracker.apply_request(r);
    endtask

    task automatic push_cmd(input cmd_t op, input logic [11:0] sbase, input logic [12:0] slen,
                            input logic [11:0] laddr, input logic [31:0] ldata);
        req_t r;
        r.cmd        = op;
        r.sound_base = sbase;
        r.sound_len  = slen;
        r.load_addr  = laddr;
        r.load_data  = ldata;
        push_request(r);
    endtask

    initial
    begin
        req_t      r;
        bit [11:0] need;
        int        pick;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle block, then four voices over a wrapped and a zero-length sound
        push_cmd(CMD_TICK, 12'd0, 13'd0, 12'd0, 32'd0);
        push_cmd(CMD_STOP, 12'd0, 13'd0, 12'd0, 32'd0);
        push_cmd(CMD_LOAD, 12'd0, 13'd0, 12'd0, 32'hFFFF_FFFF);
        push_cmd(CMD_LOAD, 12'd0, 13'd0, 12'd1, 32'h0000_0000);
        push_cmd(CMD_LOAD, 12'd0, 13'd0, 12'd2, 32'h0123_4567);
        push_cmd(CMD_LOAD, 12'd0, 13'd0, 12'd4095, 32'h89AB_CDEF);
        push_cmd(CMD_LOAD, 12'd0, 13'd0, 12'd3, 32'hFEDC_BA98);
        push_cmd(CMD_PLAY, 12'd0, 13'd1, 12'd0, 32'd0);
        push_cmd(CMD_PLAY, 12'd4095, 13'd3, 12'd0, 32'd0);
        push_cmd(CMD_PLAY, 12'd2, 13'd0, 12'd0, 32'd0);
        push_cmd(CMD_PLAY, 12'd1, 13'd3, 12'd0, 32'd0);
        push_cmd(CMD_PLAY, 12'd3, 13'd4096, 12'd0, 32'd0);
        repeat (10) push_cmd(CMD_TICK, 12'd0, 13'd0, 12'd0, 32'd0);
        push_cmd(CMD_STOP, 12'd0, 13'd0, 12'd0, 32'd0);
        push_cmd(CMD_TICK, 12'd0, 13'd0, 12'd0, 32'd0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            steady       = (i >= STEADY_LO && i < STEADY_HI);
            r.sound_base = BASE_W'($urandom);
            r.sound_len  = LEN_W'($urandom);
            r.load_addr  = BASE_W'($urandom);
            r.load_data  = $urandom;
            pick         = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // fill a word on demand so no voice reads an unloaded entry
                if (!tracker.tick_needs_word(need))
                    r.cmd = CMD_TICK;
                else if ($urandom_range(0, 9) < 8)
                begin
                    r.cmd       = CMD_LOAD;
                    r.load_addr = need;
                end
                else
                    r.cmd = CMD_STOP;
            end
            else if (pick < 71)
            begin
                r.cmd = CMD_PLAY;
                if ($urandom_range(0, 9) < 6)
                    r.sound_base = BASE_W'($urandom_range(0, 63));
                case ($urandom_range(0, 9))
                    0:             r.sound_len = '0;
                    1, 2, 3, 4, 5: r.sound_len = LEN_W'($urandom_range(1, 4));
                    6, 7, 8:       r.sound_len = LEN_W'($urandom_range(5, 40));
                    default:       ;
                endcase
            end
            else if (pick < 97)
            begin
                r.cmd = CMD_LOAD;
                if ($urandom_range(0, 9) < 6)
                    r.load_addr = BASE_W'($urandom_range(0, 63));
                case ($urandom_range(0, 9))
                    0:       r.load_data = '0;
                    1:       r.load_data = '1;
                    default: ;
                endcase
            end
            else
                r.cmd = CMD_STOP;
            push_request(r);
        end

        steady = 1'b0;
        req_valid <= 1'b0;
        while (tracker.expected_mix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests %0d: ticks %0d (%0d mixed, up to %0d voices), plays %0d (%0d refused)",
                 tracker.n_req, tracker.n_tick, tracker.n_mixed, tracker.max_voices,
                 tracker.n_play, tracker.n_refused);
        $display("loads %0d, stop-alls %0d, errors %0d",
                 tracker.n_load, tracker.n_stop, tracker.errors);
        if (tracker.errors == 0 && tracker.expected_mix.size() == 0)
            $display("packed_nibble_audio_mixer regression: pass");
        else
            $display("packed_nibble_audio_mixer regression: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("packed_nibble_audio_mixer regression: fail");
        $finish;
    end

endmodule
